[design/nrkm_pkg.sv]
// nrkm_pkg: shared types and fixed field widths for the natural-run k-way merge
// depends on nothing; used by the channel interfaces and the merge top level
package nrkm_pkg;

  localparam int SRC_W = 3;
  localparam int KEY_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

[design/nrkm_in_if.sv]
// nrkm_in_if: valid/ready channel carrying one merge input item
// depends on nrkm_pkg for field widths
interface nrkm_in_if;
  logic                             valid;
  logic                             ready;
  logic                             load;
  logic [nrkm_pkg::SRC_W-1:0]       src;
  logic signed [nrkm_pkg::KEY_W-1:0] key;
  logic                             has_key;
  logic                             load_done;

  modport source (output valid, load, src, key, has_key, load_done, input ready);
  modport sink (input valid, load, src, key, has_key, load_done, output ready);
endinterface

[design/nrkm_out_if.sv]
// nrkm_out_if: valid/ready channel carrying one merge result item
// depends on nrkm_pkg for field widths
interface nrkm_out_if;
  logic                              valid;
  logic                              ready;
  logic [nrkm_pkg::SRC_W-1:0]        out_source;
  logic signed [nrkm_pkg::KEY_W-1:0] out_key;
  logic                              round_end;

  modport source (output valid, out_source, out_key, round_end, input ready);
  modport sink (input valid, out_source, out_key, round_end, output ready);
endinterface

[design/nrkm_ram.sv]
// nrkm_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module nrkm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/natural_run_kway_merge.sv]
// natural_run_kway_merge: k-way merge engine for one natural-run sort round
// a selecting item runs ST_SCAN, ST_DRAIN, then ST_FINISH, which registers its result;
// no item is taken until back in ST_IDLE; an item with no result leaves the engine idle
// one comparator walks the head RAM one source per cycle; a held result stalls the finish
// reset (rst, synchronous): sources inactive, last key at most negative, not awaiting
// depends on nrkm_pkg, nrkm_in_if, nrkm_out_if, nrkm_ram
module natural_run_kway_merge #(
  parameter int SOURCES  = 8,
  parameter int KEY_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  nrkm_in_if.sink    items,
  nrkm_out_if.source results
);

  localparam int IW = $clog2(SOURCES);
  localparam logic [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS - 1){1'b0}}};

  nrkm_pkg::state_t state;

  logic [SOURCES-1:0]  active;
  logic [KEY_BITS-1:0] prev_key;
  logic [IW-1:0]       popped;
  logic                awaiting;

  logic [IW-1:0]       idx;
  logic [IW-1:0]       cmp_idx;
  logic                cmp_v;
  logic                found;
  logic [IW-1:0]       best_idx;
  logic [KEY_BITS-1:0] best_key;

  logic                          o_valid;
  logic [nrkm_pkg::SRC_W-1:0]    o_source;
  logic [nrkm_pkg::KEY_W-1:0]    o_key;
  logic                          o_end;

  logic                accept;
  logic [KEY_BITS-1:0] key_in;
  logic                src_ok;
  logic                repl_ok;
  logic                we;
  logic [IW-1:0]       waddr;
  logic [IW-1:0]       raddr;
  logic [KEY_BITS-1:0] rdata;
  logic                better;
  logic                out_free;

  assign accept   = items.valid && items.ready;
  assign key_in   = KEY_BITS'($unsigned(items.key));
  assign src_ok   = {29'd0, items.src} < 32'(SOURCES);
  assign repl_ok  = items.has_key && ($signed(key_in) >= $signed(prev_key));
  assign raddr    = idx;
  assign out_free = !o_valid || results.ready;
  assign better   = active[cmp_idx] && (!found || ($signed(rdata) < $signed(best_key)));

  always_comb begin
    we    = 1'b0;
    waddr = popped;
    if (accept) begin
      if (items.load) begin
        we    = !awaiting && src_ok && items.has_key;
        waddr = IW'(items.src);
      end else begin
        we    = awaiting && repl_ok;
      end
    end
  end

  nrkm_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(SOURCES)
  ) u_heads (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(key_in),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign items.ready        = (state == nrkm_pkg::ST_IDLE);
  assign results.valid      = o_valid;
  assign results.out_source = o_source;
  assign results.out_key    = o_key;
  assign results.round_end  = o_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= nrkm_pkg::ST_IDLE;
      active   <= '0;
      prev_key <= KEY_MIN;
      popped   <= '0;
      awaiting <= 1'b0;
      o_valid  <= 1'b0;
      cmp_v    <= 1'b0;
      found    <= 1'b0;
      idx      <= '0;
    end else begin
      if (o_valid && results.ready && state != nrkm_pkg::ST_FINISH) begin
        o_valid <= 1'b0;
      end
      // one head per cycle through the shared comparator
      if (cmp_v && better) begin
        found    <= 1'b1;
        best_idx <= cmp_idx;
        best_key <= rdata;
      end
      case (state)
        nrkm_pkg::ST_IDLE: begin
          if (accept) begin
            if (items.load) begin
              if (!awaiting) begin
                if (src_ok) begin
                  active[IW'(items.src)] <= items.has_key;
                end
                if (items.load_done) begin
                  found <= 1'b0;
                  idx   <= '0;
                  state <= nrkm_pkg::ST_SCAN;
                end
              end
            end else if (awaiting) begin
              if (repl_ok) begin
                active[popped] <= 1'b1;
              end
              awaiting <= 1'b0;
              found    <= 1'b0;
              idx      <= '0;
              state    <= nrkm_pkg::ST_SCAN;
            end
          end
        end
        nrkm_pkg::ST_SCAN: begin
          cmp_v   <= 1'b1;
          cmp_idx <= idx;
          if (idx == IW'(SOURCES - 1)) begin
            state <= nrkm_pkg::ST_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        nrkm_pkg::ST_DRAIN: begin
          cmp_v <= 1'b0;
          state <= nrkm_pkg::ST_FINISH;
        end
        nrkm_pkg::ST_FINISH: begin
          if (out_free) begin
            o_valid <= 1'b1;
            if (found) begin
              o_source         <= nrkm_pkg::SRC_W'(best_idx);
              o_key            <= nrkm_pkg::KEY_W'(best_key);
              o_end            <= 1'b0;
              prev_key         <= best_key;
              popped           <= best_idx;
              active[best_idx] <= 1'b0;
              awaiting         <= 1'b1;
            end else begin
              // nothing left: round end and back to the cleared state
              o_source <= '0;
              o_key    <= '0;
              o_end    <= 1'b1;
              active   <= '0;
              prev_key <= KEY_MIN;
              popped   <= '0;
              awaiting <= 1'b0;
            end
            state <= nrkm_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= nrkm_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule
